// ----- sv/arpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants
// Result codes, protocol constants and the request record passed from the
// classifier to the cache engine.
// ----------------------------------------------------------------------------
package arpc_pkg;

	typedef enum logic [3:0] {
		KIND_DROPPED   = 4'd0,
		KIND_ARP_CACHE = 4'd1,
		KIND_ARP_REPLY = 4'd2,
		KIND_IP_OTHER  = 4'd3,
		KIND_ICMP      = 4'd4,
		KIND_TCP       = 4'd5,
		KIND_UDP       = 4'd6,
		KIND_PROTO     = 4'd7,
		KIND_HIT       = 4'd8,
		KIND_MISS      = 4'd9,
		KIND_BAD_IP    = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		ACT_DONE   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_LOOKUP = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_OUT  = 2'd2
	} state_t;

	localparam logic [15:0] TYPE_ARP   = 16'h0806;
	localparam logic [15:0] TYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [11:0] ETH_HDR    = 12'd14;
	localparam logic [11:0] ARP_MIN    = 12'd42;
	localparam logic [11:0] IPV4_MIN   = 12'd34;
	localparam logic [15:0] ARP_OP_REQ = 16'd1;
	localparam logic [0:0]  REG_LOCAL_IP  = 1'b0;
	localparam logic [0:0]  REG_LOCAL_MAC = 1'b1;

	typedef struct packed {
		act_t        act;
		kind_t       kind;
		logic [31:0] key_ip;
		logic [47:0] key_mac;
		logic [15:0] hw_type;
		logic [15:0] ptype;
		logic [15:0] data_len;
	} req_t;

endpackage
`default_nettype wire

// ----- sv/arp_responder_with_cache_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_responder_with_cache_core: ARP responder with ARP cache
// Items that need no cache access go straight from the queue to the result;
// cache inserts and lookups scan the cache, one slot scanned per cycle.
// A two-entry queue takes new items while the cache scan runs, until it is full.
// Reset clears the valid bits and registers; the result receiver cannot stall.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        op,
	input  wire logic [11:0] frame_len,
	input  wire logic [15:0] ethertype,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [15:0] arp_hw_type,
	input  wire logic [15:0] arp_proto_type,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] dest_ip,
	input  wire logic [7:0]  ip_version_ihl,
	input  wire logic [15:0] ip_total_length,
	input  wire logic [7:0]  ip_protocol,
	output logic             result_valid,
	output logic [3:0]       result_kind,
	output logic [47:0]      reply_dest_mac,
	output logic [31:0]      reply_dest_ip,
	output logic [15:0]      reply_hw_type,
	output logic [15:0]      reply_proto_type,
	output logic [15:0]      ip_data_len,
	output logic [47:0]      found_mac,
	output logic             cache_full
);
	import arpc_pkg::*;

	logic [31:0] stn_ip_q;
	logic [47:0] local_mac_q;
	req_t        head;
	logic        not_empty, full, pop, idle, accept;

	// The MAC register is held for the reply sender; nothing but an assertion reads it here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stn_ip_q <= '0;
			local_mac_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_LOCAL_IP)
				stn_ip_q <= cfg_data[31:0];
			else if (cfg_index == REG_LOCAL_MAC)
				local_mac_q <= cfg_data;
		end
	end

	assign busy = full;
	assign accept = start && !busy;

	arpc_front u_front (
		.clk, .arst_n, .accept, .op, .frame_len, .ethertype, .arp_opcode,
		.arp_hw_type, .arp_proto_type, .sender_mac, .sender_ip, .dest_ip,
		.ip_version_ihl, .ip_total_length, .ip_protocol,
		.stn_ip(stn_ip_q), .pop, .head, .not_empty, .full
	);

	arpc_back #(.ENTRIES(CACHE_ENTRIES)) u_back (
		.clk, .arst_n, .head, .not_empty, .pop, .idle, .done(result_valid),
		.result_kind, .reply_dest_mac, .reply_dest_ip, .reply_hw_type,
		.reply_proto_type, .ip_data_len, .found_mac, .cache_full
	);

	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> !idle)
		else $error("result strobe while engine idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_LOCAL_MAC) |=> local_mac_q == $past(cfg_data))
		else $error("MAC register write lost");
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> not_empty)
		else $error("busy with empty queue");

endmodule
`default_nettype wire

// ----- sv/arpc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_front: frame classifier
// Classifies one accepted item and pushes a request into a two-entry queue.
// ----------------------------------------------------------------------------
module arpc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           op,
	input  wire logic [11:0]    frame_len,
	input  wire logic [15:0]    ethertype,
	input  wire logic [15:0]    arp_opcode,
	input  wire logic [15:0]    arp_hw_type,
	input  wire logic [15:0]    arp_proto_type,
	input  wire logic [47:0]    sender_mac,
	input  wire logic [31:0]    sender_ip,
	input  wire logic [31:0]    dest_ip,
	input  wire logic [7:0]     ip_version_ihl,
	input  wire logic [15:0]    ip_total_length,
	input  wire logic [7:0]     ip_protocol,
	input  wire logic [31:0]    stn_ip,
	input  wire logic           pop,
	output arpc_pkg::req_t      head,
	output logic                not_empty,
	output logic                full
);
	import arpc_pkg::*;

	req_t       req;
	req_t       fifo_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	always_comb begin
		req = '0;
		req.act = ACT_DONE;
		req.kind = KIND_DROPPED;
		if (op) begin
			req.act = ACT_LOOKUP;
			req.key_ip = dest_ip;
		end else if (frame_len < ETH_HDR) begin
			req.kind = KIND_DROPPED;
		end else if (ethertype == TYPE_ARP) begin
			if (frame_len >= ARP_MIN) begin
				req.act = ACT_INSERT;
				req.key_ip = sender_ip;
				req.key_mac = sender_mac;
				if (arp_opcode == ARP_OP_REQ && dest_ip == stn_ip) begin
					req.kind = KIND_ARP_REPLY;
					req.hw_type = arp_hw_type;
					req.ptype = arp_proto_type;
				end else begin
					req.kind = KIND_ARP_CACHE;
				end
			end
		end else if (ethertype == TYPE_IPV4) begin
			if (frame_len < IPV4_MIN || ip_version_ihl[7:4] != 4'd4) begin
				req.kind = KIND_BAD_IP;
			end else begin
				req.data_len = ip_total_length - {10'd0, ip_version_ihl[3:0], 2'b00};
				if (dest_ip != stn_ip)
					req.kind = KIND_IP_OTHER;
				else if (ip_protocol == PROTO_ICMP)
					req.kind = KIND_ICMP;
				else if (ip_protocol == PROTO_TCP)
					req.kind = KIND_TCP;
				else if (ip_protocol == PROTO_UDP)
					req.kind = KIND_UDP;
				else
					req.kind = KIND_PROTO;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			fifo_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, pop};
		end
	end

	assign head = fifo_q[rd_q];
	assign not_empty = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);

	assert property (@(posedge clk) disable iff (!arst_n) !(accept && full))
		else $error("request queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("pop from empty request queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- sv/arpc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_back: cache engine
// Scans the cache one slot per cycle to insert or look up (items with no cache
// access skip the scan), then emits the result for one cycle.
// ----------------------------------------------------------------------------
module arpc_back #(
	parameter int ENTRIES = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  arpc_pkg::req_t       head,
	input  wire logic            not_empty,
	output logic                 pop,
	output logic                 idle,
	output logic                 done,
	output logic [3:0]           result_kind,
	output logic [47:0]          reply_dest_mac,
	output logic [31:0]          reply_dest_ip,
	output logic [15:0]          reply_hw_type,
	output logic [15:0]          reply_proto_type,
	output logic [15:0]          ip_data_len,
	output logic [47:0]          found_mac,
	output logic                 cache_full
);
	import arpc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	state_t          state_q, state_d;
	req_t            cur_q;
	logic [CW-1:0]   idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]     mem_ip [ENTRIES];
	logic [47:0]     mem_mac [ENTRIES];
	logic [31:0]     rd_ip_q;
	logic [47:0]     rd_mac_q;
	logic            rd_ok_q;
	logic            rd_live_q;
	logic            hit_q;
	logic            full_q;
	logic [47:0]     mac_q;
	logic            scan_end;
	logic            ins_now;
	logic [IW-1:0]   slot;

	assign slot = idx_q[IW-1:0];
	// A free slot is found directly from the valid bits at the scan index.
	assign ins_now = (state_q == ST_SCAN) && (cur_q.act == ACT_INSERT) &&
		(idx_q < CW'(ENTRIES)) && !valid_q[slot];
	// Lookups read the memory through a register behind the index, so compare lags.
	assign scan_end = (cur_q.act == ACT_INSERT) ?
		(ins_now || idx_q == CW'(ENTRIES)) :
		((rd_live_q && rd_ok_q && rd_ip_q == cur_q.key_ip) ||
		 (idx_q == CW'(ENTRIES) && !rd_live_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (not_empty) state_d = (head.act == ACT_DONE) ? ST_OUT : ST_SCAN;
			ST_SCAN: if (scan_end) state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		done = 1'b0;
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = not_empty;
				idle = !not_empty;
			end
			ST_SCAN: ;
			ST_OUT:  done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ins_now) begin
			mem_ip[slot] <= cur_q.key_ip;
			mem_mac[slot] <= cur_q.key_mac;
		end
		rd_ip_q <= mem_ip[slot];
		rd_mac_q <= mem_mac[slot];
		if (pop)
			cur_q <= head;
		if (state_q == ST_SCAN && rd_live_q && rd_ok_q && rd_ip_q == cur_q.key_ip &&
			cur_q.act == ACT_LOOKUP)
			mac_q <= rd_mac_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			rd_ok_q <= 1'b0;
			rd_live_q <= 1'b0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_live_q <= (state_q == ST_SCAN) && (idx_q < CW'(ENTRIES)) && !scan_end;
			rd_ok_q <= (idx_q < CW'(ENTRIES)) && valid_q[slot];
			if (ins_now)
				valid_q[slot] <= 1'b1;
			if (pop) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				full_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (idx_q < CW'(ENTRIES) && !scan_end)
					idx_q <= idx_q + CW'(1);
				if (scan_end) begin
					if (cur_q.act == ACT_INSERT)
						full_q <= !ins_now;
					else
						hit_q <= (rd_live_q && rd_ok_q && rd_ip_q == cur_q.key_ip);
				end
			end
		end
	end

	always_comb begin
		result_kind = cur_q.kind;
		reply_dest_mac = '0;
		reply_dest_ip = '0;
		reply_hw_type = '0;
		reply_proto_type = '0;
		ip_data_len = cur_q.data_len;
		found_mac = '0;
		cache_full = (cur_q.act == ACT_INSERT) && full_q;
		if (cur_q.act == ACT_LOOKUP) begin
			result_kind = hit_q ? KIND_HIT : KIND_MISS;
			found_mac = hit_q ? mac_q : '0;
		end
		if (cur_q.kind == KIND_ARP_REPLY && cur_q.act == ACT_INSERT) begin
			reply_dest_mac = cur_q.key_mac;
			reply_dest_ip = cur_q.key_ip;
			reply_hw_type = cur_q.hw_type;
			reply_proto_type = cur_q.ptype;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		ins_now |=> valid_q[$past(slot)])
		else $error("inserted slot not marked valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && cache_full) |-> (valid_q == {ENTRIES{1'b1}}))
		else $error("cache reported full with a free slot");

endmodule
`default_nettype wire

// ----- dv/arpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker: result predictor and scoreboard for the ARP responder
// Watches accepted requests, configuration writes and result strobes, keeps
// its own copy of the ARP cache and compares every result field by field.
// ----------------------------------------------------------------------------
module arpc_checker #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        op,
	input  wire logic [11:0] frame_len,
	input  wire logic [15:0] ethertype,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [15:0] arp_hw_type,
	input  wire logic [15:0] arp_proto_type,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] dest_ip,
	input  wire logic [7:0]  ip_version_ihl,
	input  wire logic [15:0] ip_total_length,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic        result_valid,
	input  wire logic [3:0]  result_kind,
	input  wire logic [47:0] reply_dest_mac,
	input  wire logic [31:0] reply_dest_ip,
	input  wire logic [15:0] reply_hw_type,
	input  wire logic [15:0] reply_proto_type,
	input  wire logic [15:0] ip_data_len,
	input  wire logic [47:0] found_mac,
	input  wire logic        cache_full,
	output int               fail_count,
	output int               pending
);
	import arpc_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [47:0] dmac;
		logic [31:0] dip;
		logic [15:0] hwt;
		logic [15:0] prt;
		logic [15:0] plen;
		logic [47:0] fmac;
		logic        full;
	} arp_result_t;

	arp_result_t expected_results[$];
	logic [31:0] my_ip;
	logic [31:0] slot_ip [CACHE_ENTRIES];
	logic [47:0] slot_mac [CACHE_ENTRIES];
	logic        slot_used [CACHE_ENTRIES];

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic arp_result_t classify_request();
		arp_result_t r;
		logic placed;
		r = '0;
		r.kind = KIND_DROPPED;
		if (op) begin
			r.kind = KIND_MISS;
			for (int i = 0; i < CACHE_ENTRIES; i++)
				if (r.kind == KIND_MISS && slot_used[i] && slot_ip[i] == dest_ip) begin
					r.kind = KIND_HIT;
					r.fmac = slot_mac[i];
				end
		end else if (frame_len < 14) begin
			r.kind = KIND_DROPPED;
		end else if (ethertype == TYPE_ARP) begin
			if (frame_len - 14 >= 28) begin
				placed = 1'b0;
				for (int i = 0; i < CACHE_ENTRIES; i++)
					if (!placed && !slot_used[i]) begin
						slot_used[i] = 1'b1;
						slot_ip[i] = sender_ip;
						slot_mac[i] = sender_mac;
						placed = 1'b1;
					end
				r.full = !placed;
				if (arp_opcode == ARP_OP_REQ && dest_ip == my_ip) begin
					r.kind = KIND_ARP_REPLY;
					r.dmac = sender_mac;
					r.dip = sender_ip;
					r.hwt = arp_hw_type;
					r.prt = arp_proto_type;
				end else begin
					r.kind = KIND_ARP_CACHE;
				end
			end
		end else if (ethertype == TYPE_IPV4) begin
			if (frame_len - 14 < 20 || ip_version_ihl[7:4] != 4'd4) begin
				r.kind = KIND_BAD_IP;
			end else begin
				r.plen = ip_total_length - {10'd0, ip_version_ihl[3:0], 2'b00};
				if (dest_ip != my_ip) r.kind = KIND_IP_OTHER;
				else if (ip_protocol == PROTO_ICMP) r.kind = KIND_ICMP;
				else if (ip_protocol == PROTO_TCP) r.kind = KIND_TCP;
				else if (ip_protocol == PROTO_UDP) r.kind = KIND_UDP;
				else r.kind = KIND_PROTO;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		arp_result_t want;
		if (!arst_n) begin
			my_ip = '0;
			for (int i = 0; i < CACHE_ENTRIES; i++) slot_used[i] = 1'b0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Results are checked before this edge's request is predicted.
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result kind", 64'(result_kind), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (result_kind != want.kind)
						report_mismatch("kind", 64'(result_kind), 64'(want.kind));
					if (reply_dest_mac != want.dmac)
						report_mismatch("reply_dest_mac", 64'(reply_dest_mac), 64'(want.dmac));
					if (reply_dest_ip != want.dip)
						report_mismatch("reply_dest_ip", 64'(reply_dest_ip), 64'(want.dip));
					if (reply_hw_type != want.hwt)
						report_mismatch("reply_hw_type", 64'(reply_hw_type), 64'(want.hwt));
					if (reply_proto_type != want.prt)
						report_mismatch("reply_proto_type", 64'(reply_proto_type),
							64'(want.prt));
					if (ip_data_len != want.plen)
						report_mismatch("ip_data_len", 64'(ip_data_len), 64'(want.plen));
					if (found_mac != want.fmac)
						report_mismatch("found_mac", 64'(found_mac), 64'(want.fmac));
					if (cache_full != want.full)
						report_mismatch("cache_full", 64'(cache_full), 64'(want.full));
				end
			end
			if (cfg_we && cfg_index == REG_LOCAL_IP) my_ip = cfg_data[31:0];
			if (start && !busy) expected_results.push_back(classify_request());
			pending = expected_results.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ARP responder with cache
// Drives directed and random frames and lookups, mostly with random gaps; rewrites
// the local address registers between phases and lets the checker judge.
// ----------------------------------------------------------------------------
module tb_top;
	import arpc_pkg::*;

	localparam int CACHE_WAIT = 24;

	logic clk, arst_n, start, busy, cfg_we, cfg_index, op;
	logic [47:0] cfg_data, sender_mac;
	logic [11:0] frame_len;
	logic [15:0] ethertype, arp_opcode, arp_hw_type, arp_proto_type, ip_total_length;
	logic [31:0] sender_ip, dest_ip;
	logic [7:0] ip_version_ihl, ip_protocol;
	logic result_valid, cache_full;
	logic [3:0] result_kind;
	logic [47:0] reply_dest_mac, found_mac;
	logic [31:0] reply_dest_ip;
	logic [15:0] reply_hw_type, reply_proto_type, ip_data_len;
	int fail_count, pending;
	int idle_cycles;
	logic [31:0] cur_ip;
	logic [31:0] known_ips [8];
	bit gaps_on;

	arp_responder_with_cache_core DUT (.*);
	arpc_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: cycles with no request accepted and no result seen.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [47:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_LOCAL_IP) cur_ip = value[31:0];
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (CACHE_WAIT) @(posedge clk);
	endtask

	// Holds the request until accepted; random gaps beforehand when gaps are on.
	task automatic send_request(input logic o, input logic [11:0] fl, input logic [15:0] et,
		input logic [15:0] opc, input logic [31:0] sip, input logic [31:0] dip,
		input logic [7:0] vihl, input logic [15:0] tl, input logic [7:0] pr);
		if (gaps_on && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 38) @(posedge clk);
		end
		op <= o; frame_len <= fl; ethertype <= et; arp_opcode <= opc;
		arp_hw_type <= 16'($urandom); arp_proto_type <= 16'($urandom);
		sender_mac <= 48'({$urandom, $urandom}); sender_ip <= sip; dest_ip <= dip;
		ip_version_ihl <= vihl; ip_total_length <= tl; ip_protocol <= pr;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_request();
		logic [31:0] sip, dip;
		logic [15:0] et, opc;
		logic [11:0] fl;
		logic [7:0] vihl, pr;
		int pick;
		pick = $urandom_range(99);
		sip = known_ips[$urandom_range(7)];
		dip = $urandom_range(2) == 0 ? cur_ip : known_ips[$urandom_range(7)];
		if ($urandom_range(9) == 0) dip = $urandom;
		fl = $urandom_range(9) == 0 ? 12'($urandom) : 12'($urandom_range(2048, 34));
		opc = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2, 1));
		vihl = $urandom_range(4) == 0 ? 8'($urandom) : {4'd4, 4'($urandom)};
		case ($urandom_range(5))
			0: pr = PROTO_ICMP;
			1: pr = PROTO_TCP;
			2: pr = PROTO_UDP;
			default: pr = 8'($urandom);
		endcase
		if (pick < 35) et = TYPE_ARP;
		else if (pick < 70) et = TYPE_IPV4;
		else et = 16'($urandom);
		send_request(pick >= 85, fl, et, opc, sip, dip, vihl, 16'($urandom), pr);
	endtask

	initial begin
		arst_n = 1'b0;
		{start, cfg_we, cfg_index, op} = '0;
		{cfg_data, sender_mac, sender_ip, dest_ip} = '0;
		{frame_len, ethertype, arp_opcode, arp_hw_type, arp_proto_type} = '0;
		{ip_version_ihl, ip_total_length, ip_protocol} = '0;
		gaps_on = 1'b1;
		cur_ip = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register extremes, every kind, short frames, full cache.
		write_reg(REG_LOCAL_IP, 48'hFFFF_FFFF);
		write_reg(REG_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);
		send_request(1'b1, 12'd0, 16'h0, 16'h0, 32'h0, 32'h0, 8'h0, 16'h0, 8'h0);
		send_request(1'b0, 12'd13, TYPE_ARP, 16'd1, 32'h1, cur_ip, 8'h45, 16'd0, 8'h0);
		send_request(1'b0, 12'd41, TYPE_ARP, 16'd1, 32'h1, cur_ip, 8'h45, 16'd0, 8'h0);
		send_request(1'b0, 12'd42, TYPE_ARP, 16'd1, 32'h0, cur_ip, 8'h45, 16'd0, 8'h0);
		send_request(1'b0, 12'hFFF, TYPE_ARP, 16'd2, 32'hFFFF_FFFF, 32'h5, 8'hFF, 16'hFFFF, 8'hFF);
		send_request(1'b1, 12'd60, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 8'h0, 16'h0, 8'h0);
		send_request(1'b0, 12'd33, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h45, 16'd100, PROTO_TCP);
		send_request(1'b0, 12'd34, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h35, 16'd100, PROTO_TCP);
		send_request(1'b0, 12'd34, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h40, 16'd0, PROTO_ICMP);
		send_request(1'b0, 12'd34, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h4F, 16'd3, PROTO_TCP);
		send_request(1'b0, 12'd2048, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h45, 16'hFFFF, PROTO_UDP);
		send_request(1'b0, 12'd100, TYPE_IPV4, 16'd0, 32'h0, cur_ip, 8'h45, 16'd60, 8'd0);
		send_request(1'b0, 12'd100, TYPE_IPV4, 16'd0, 32'h0, 32'h0, 8'h45, 16'd60, PROTO_UDP);
		send_request(1'b0, 12'd100, 16'hFFFF, 16'd1, 32'h0, cur_ip, 8'h45, 16'd60, PROTO_UDP);
		for (int i = 0; i < 16; i++)
			send_request(1'b0, 12'd60, TYPE_ARP, 16'd1, 32'(i + 100), 32'h7, 8'h0, 16'h0, 8'h0);
		send_request(1'b0, 12'd60, TYPE_ARP, 16'd1, 32'h9, cur_ip, 8'h0, 16'h0, 8'h0);
		drain();

		// Random phases; the cache is already full from the directed part, so lookups
		// hit the addresses stored there, together with fresh misses.
		for (int i = 0; i < 8; i++) known_ips[i] = i < 4 ? 32'(i + 100) : $urandom;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_reg(REG_LOCAL_IP, 48'h0);
				1: write_reg(REG_LOCAL_IP, 48'd100);
				default: write_reg(REG_LOCAL_IP, {16'h0, $urandom});
			endcase
			write_reg(REG_LOCAL_MAC, phase == 0 ? 48'h0 : 48'({$urandom, $urandom}));
			gaps_on = phase != 2;
			for (int n = 0; n < 210; n++) random_request();
			drain();
		end

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/arpc_pkg.sv
sv/arpc_front.sv
sv/arpc_back.sv
sv/arp_responder_with_cache_core.sv
dv/arpc_checker.sv
dv/tb_top.sv
